>>> rtl/vcp_load_factor_marker_top_macros.svh
// Assertion macros used by the checker of the load marking block.
`ifndef VCP_LOAD_FACTOR_MARKER_TOP_MACROS_SVH
`define VCP_LOAD_FACTOR_MARKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LFM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("load marker assertion failed");

// Next-cycle implication, disabled while reset is low.
`define LFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("load marker assertion failed");

`endif

>>> rtl/lfm_pkg.sv
package lfm_pkg;

    localparam int WINDOW_MAX      = 32;
    localparam int QUEUE_LIMIT_MAX = 1024;

    localparam int RING_AW    = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int DEPTH_W    = 11;
    localparam int SUM_W      = 16;
    localparam int ARR_W      = 16;
    localparam int QW_W       = 10;
    localparam int CAP_W      = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // Output tdata layout.
    localparam int OUT_NEW_LOAD_LSB = 0;
    localparam int OUT_DROPPED_BIT  = 2;
    localparam int OUT_CLASS_LSB    = 3;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PACKETS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LEN   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_QUEUE_WEIGHT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY     = 2'd3;

    typedef enum logic [1:0] {
        REQ_ARRIVAL = 2'd0,
        REQ_SAMPLE  = 2'd1,
        REQ_LOAD    = 2'd2,
        REQ_UNUSED  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CODE_UNSUPPORTED = 2'd0,
        CODE_LOW         = 2'd1,
        CODE_HIGH        = 2'd2,
        CODE_OVER        = 2'd3
    } t_load;

    typedef struct packed {
        t_req               req;
        t_load              prev;
        logic [DEPTH_W-1:0] depth;
        logic               remove;
        logic               add;
        logic [CNT_W-1:0]   cnt;
    } t_stage;

endpackage

>>> rtl/vcp_load_factor_marker_top.sv
// Router load marker. One item is accepted per cycle while the output is not
// stalled; its result passes through the stage register r_p1 into the output
// register r_out_data. Sample depths live in a 32-entry ring memory with a
// registered read; the second stage applies the evicted sample to the running
// sum, classifies the load with three small products and two compares, and
// marks arrivals. A full output register stalls the pipeline through tready;
// no reset sweep is needed.
module vcp_load_factor_marker_top import lfm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [1:0] prev_load, [12:2] queue_depth
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] req_type
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [1:0] new_load, [2] dropped, [4:3] load_class
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [DEPTH_W-1:0] r_max_packets;
    logic [CNT_W-1:0]   r_window_len;
    logic [QW_W-1:0]    r_queue_weight;
    logic [CAP_W-1:0]   r_capacity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_packets  <= DEPTH_W'(25);
            r_window_len   <= CNT_W'(20);
            r_queue_weight <= QW_W'(128);
            r_capacity     <= CAP_W'(9600);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MAX_PACKETS:  r_max_packets  <= i_cfg_data[DEPTH_W-1:0];
                CFG_WINDOW_LEN:   r_window_len   <= i_cfg_data[CNT_W-1:0];
                CFG_QUEUE_WEIGHT: r_queue_weight <= i_cfg_data[QW_W-1:0];
                CFG_CAPACITY:     r_capacity     <= i_cfg_data[CAP_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input side and ring pointer stage.
    t_req               s_req;
    t_load              s_prev;
    logic [DEPTH_W-1:0] s_depth;
    logic               s_accept;
    logic               s_sample;

    logic [RING_AW-1:0] r_head;
    logic [CNT_W-1:0]   r_count;
    logic               r_ent0_valid;

    logic [CNT_W-1:0]   win;
    logic               remove;
    logic [CNT_W-1:0]   cnt_mid;
    logic [RING_AW-1:0] head_mid;
    logic               add;
    logic [RING_AW-1:0] wr_addr;
    logic [CNT_W-1:0]   n_count;

    assign s_req    = t_req'(i_s_tuser);
    assign s_prev   = t_load'(i_s_tdata[1:0]);
    assign s_depth  = i_s_tdata[DEPTH_W+1:2];
    assign s_accept = i_s_tvalid && o_s_tready;
    assign s_sample = (s_req == REQ_SAMPLE);

    always_comb begin
        win      = (r_window_len > CNT_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : r_window_len;
        remove   = (r_count >= win) && (r_count != '0);
        cnt_mid  = remove ? r_count - CNT_W'(1) : r_count;
        head_mid = remove ? r_head + RING_AW'(1) : r_head;
        add      = (cnt_mid < CNT_W'(WINDOW_MAX));
        wr_addr  = head_mid + cnt_mid[RING_AW-1:0];
        n_count  = add ? cnt_mid + CNT_W'(1) : cnt_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_count      <= CNT_W'(1);
            r_ent0_valid <= 1'b0;
        end else if (s_accept && s_sample) begin
            r_head  <= head_mid;
            r_count <= n_count;
            if (add && (wr_addr == '0)) begin
                r_ent0_valid <= 1'b1;
            end
        end
    end

    // Ring memory. The read returns the entry as it was before this edge's
    // write, which is the sample being evicted when both hit the same entry.
    logic [DEPTH_W-1:0] ring_mem [WINDOW_MAX];
    logic [DEPTH_W-1:0] r_rd;
    logic               r_rd_blank;

    always_ff @(posedge i_clk) begin
        if (s_accept && s_sample) begin
            r_rd       <= ring_mem[r_head];
            r_rd_blank <= (r_head == '0) && !r_ent0_valid;
            if (add) begin
                ring_mem[wr_addr] <= s_depth;
            end
        end
    end

    // Second stage: sum, counter, class and marking.
    logic               r_p1_valid;
    t_stage             r_p1;
    logic               r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic               adv1;
    logic               fire1;

    logic [SUM_W-1:0]   r_sum;
    logic [ARR_W-1:0]   r_arrivals;
    t_load              r_class;

    assign adv1       = !r_out_valid || i_m_tready;
    assign fire1      = r_p1_valid && adv1;
    assign o_s_tready = !r_p1_valid || adv1;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_p1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_p1.req    <= s_req;
            r_p1.prev   <= s_prev;
            r_p1.depth  <= s_depth;
            r_p1.remove <= s_sample && remove;
            r_p1.add    <= s_sample && add;
            r_p1.cnt    <= s_sample ? n_count : r_count;
        end
    end

    function automatic t_load raise_code(t_load cls, t_load prev);
        t_load res;
        unique case (cls)
            CODE_LOW:  res = (prev == CODE_UNSUPPORTED) ? CODE_LOW : prev;
            CODE_HIGH: res = (prev == CODE_UNSUPPORTED || prev == CODE_LOW) ? CODE_HIGH : prev;
            default:   res = CODE_OVER;
        endcase
        return res;
    endfunction

    logic [DEPTH_W-1:0]     old_sample;
    logic [DEPTH_W-1:0]     limit;
    logic [ARR_W+CNT_W-1:0] prod_arr;
    logic [QW_W+SUM_W-1:0]  prod_queue;
    logic [CNT_W+CAP_W-1:0] den;
    logic [30:0]            num;
    logic [33:0]            num5;
    logic [33:0]            den4;
    t_load                  cls_calc;

    logic [SUM_W-1:0]  n_sum;
    logic [ARR_W-1:0]  n_arrivals;
    t_load             n_class;
    t_load             new_load;
    logic              dropped;

    always_comb begin
        old_sample = r_rd_blank ? '0 : r_rd;
        limit      = (r_max_packets > DEPTH_W'(QUEUE_LIMIT_MAX)) ?
                     DEPTH_W'(QUEUE_LIMIT_MAX) : r_max_packets;

        // rho = (256*arrivals*n + k*sum) / (n*capacity), compared without division.
        prod_arr   = r_arrivals * r_p1.cnt;
        prod_queue = r_queue_weight * r_sum;
        den        = r_p1.cnt * r_capacity;
        num        = 31'({prod_arr, 8'b0}) + 31'(prod_queue);
        num5       = (34'(num) << 2) + 34'(num);
        den4       = 34'(den) << 2;
        if (num5 < den4) begin
            cls_calc = CODE_LOW;
        end else if (num < 31'(den)) begin
            cls_calc = CODE_HIGH;
        end else begin
            cls_calc = CODE_OVER;
        end

        n_sum      = r_sum;
        n_arrivals = r_arrivals;
        n_class    = r_class;
        new_load   = CODE_UNSUPPORTED;
        dropped    = 1'b0;
        case (r_p1.req)
            REQ_ARRIVAL: begin
                if (r_arrivals != '1) begin
                    n_arrivals = r_arrivals + ARR_W'(1);
                end
                new_load = raise_code(r_class, r_p1.prev);
                dropped  = (r_p1.depth >= limit);
            end
            REQ_SAMPLE: begin
                n_sum = r_sum - (r_p1.remove ? SUM_W'(old_sample) : '0)
                              + (r_p1.add ? SUM_W'(r_p1.depth) : '0);
            end
            REQ_LOAD: begin
                n_class    = cls_calc;
                n_arrivals = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_arrivals  <= '0;
            r_class     <= CODE_LOW;
            r_out_valid <= 1'b0;
        end else begin
            if (adv1) begin
                r_out_valid <= r_p1_valid;
            end
            if (fire1) begin
                r_sum      <= n_sum;
                r_arrivals <= n_arrivals;
                r_class    <= n_class;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire1) begin
            r_out_data <= {3'b000, n_class, dropped, new_load};
        end
    end

endmodule

>>> rtl/lfm_checker.sv
`include "vcp_load_factor_marker_top_macros.svh"

module lfm_checker import lfm_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata
);

    logic [1:0] new_load;
    logic [1:0] load_class;
    logic       dropped;
    logic       out_stall;
    logic       marked;
    logic       unmarked;

    assign new_load   = o_m_tdata[OUT_NEW_LOAD_LSB +: 2];
    assign load_class = o_m_tdata[OUT_CLASS_LSB +: 2];
    assign dropped    = o_m_tdata[OUT_DROPPED_BIT];
    assign out_stall  = o_m_tvalid && !i_m_tready;
    assign marked     = o_m_tvalid && (new_load != CODE_UNSUPPORTED);
    assign unmarked   = o_m_tvalid && (new_load == CODE_UNSUPPORTED);

    // A stalled result stays in place.
    `LFM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_tvalid && $stable(o_m_tdata))

    // With nothing waiting at the output the input side must take a transfer.
    `LFM_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)

    // The class is always one of low, high or overload.
    `LFM_ASSERT_IMPLY(a_class_set, i_clk, i_rst_n, o_m_tvalid, load_class != CODE_UNSUPPORTED)

    // Only arrivals carry a load code, and only they can be dropped.
    `LFM_ASSERT_IMPLY(a_drop_arrival, i_clk, i_rst_n, unmarked, !dropped)

    // Marking never leaves a code below the current class.
    `LFM_ASSERT_IMPLY(a_mark_raise, i_clk, i_rst_n, marked, new_load >= load_class)

endmodule

bind vcp_load_factor_marker_top lfm_checker u_lfm_checker (.*);
